[rtl/core/infix_to_postfix_converter_top_macros.svh]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_macros.svh
// Assertion macros shared by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH

// ante holds at an edge -> cons holds at the same edge
`define ITP_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("itp assertion failed");

// expr never holds out of reset
`define ITP_ASSERT_NEVER(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("itp assertion failed");

`endif

[rtl/core/itp_pkg.sv]
// ----------------------------------------------------------------------------
// itp_pkg
// Constants, codes and lookup functions of the infix-to-postfix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    // operator stack codes
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_PLUS   = 4'd1;
    localparam logic [3:0] OP_MINUS  = 4'd2;
    localparam logic [3:0] OP_MUL    = 4'd3;
    localparam logic [3:0] OP_DIV    = 4'd4;
    localparam logic [3:0] OP_MOD    = 4'd5;
    localparam logic [3:0] OP_POW    = 4'd6;
    localparam logic [3:0] OP_PAREN  = 4'd7;
    localparam logic [3:0] OP_BRACK  = 4'd8;
    localparam logic [3:0] OP_BRACE  = 4'd9;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_INVALID  = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_MOD    = 8'h25;
    localparam logic [7:0] CH_POW    = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic [7:0] out_char;
        logic       token_start;
        logic       end_of_expr;
        logic [1:0] error_code;
    } result_t;

    // operators and openers map to their code; closers map to the matching opener
    function automatic logic [3:0] op_code(input logic [7:0] c);
        logic [3:0] r;
        case (c)
            CH_PLUS:   r = OP_PLUS;
            CH_MINUS:  r = OP_MINUS;
            CH_MUL:    r = OP_MUL;
            CH_DIV:    r = OP_DIV;
            CH_MOD:    r = OP_MOD;
            CH_POW:    r = OP_POW;
            CH_LPAREN: r = OP_PAREN;
            CH_LBRACK: r = OP_BRACK;
            CH_LBRACE: r = OP_BRACE;
            CH_RPAREN: r = OP_PAREN;
            CH_RBRACK: r = OP_BRACK;
            CH_RBRACE: r = OP_BRACE;
            default:   r = OP_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] op_prio(input logic [3:0] code);
        logic [1:0] r;
        case (code)
            OP_PLUS, OP_MINUS: r = 2'd1;
            OP_MUL, OP_DIV:    r = 2'd2;
            OP_MOD, OP_POW:    r = 2'd3;
            default:           r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] op_char(input logic [3:0] code);
        logic [7:0] r;
        case (code)
            OP_PLUS:  r = CH_PLUS;
            OP_MINUS: r = CH_MINUS;
            OP_MUL:   r = CH_MUL;
            OP_DIV:   r = CH_DIV;
            OP_MOD:   r = CH_MOD;
            OP_POW:   r = CH_POW;
            OP_PAREN: r = CH_LPAREN;
            OP_BRACK: r = CH_LBRACK;
            OP_BRACE: r = CH_LBRACE;
            default:  r = CH_NUL;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/infix_to_postfix_converter_top.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Streaming shunting-yard converter: expression characters in, postfix out.
// ----------------------------------------------------------------------------
// Input words: s_tdata carries one ASCII character, s_tuser[0] = 1 marks the
// end of the expression (stack flush, end marker). Output words carry one
// postfix character each; m_tuser flags token start, end marker and error
// code, m_tlast marks the final word caused by an input word.
// Flow: a word is taken while idle and worked on by a small sequencer around
// one operator stack port. Digits, dots, errors, spaces, pushes of openers
// and an end word after an error are done in the decode state. Operators pop
// in their pop state, then pass the finish state; a leading-minus zero goes
// out in the decode cycle at no extra cost. Closers and the end word pop in
// their own pop state, then pass the finish state; each pop goes through the
// single stack read port and the output holding stage.
// s_tready is high only while the sequencer is idle.
// Reset clears the stack count and the parser flags; the stack array itself
// needs no clearing. When the receiver stalls, words wait in the output
// register and a one-word holding stage, and the sequencer waits with them.
// ----------------------------------------------------------------------------
`default_nettype none
`include "infix_to_postfix_converter_top_macros.svh"

module infix_to_postfix_converter_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] ch
    input  wire logic [0:0] s_tuser,   // [0] mode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_char
    output logic [3:0]      m_tuser,   // [0] token_start, [1] end_of_expr, [3:2] error_code
    output logic            m_tlast
);
    import itp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP_OP,
        ST_POP_CLOSE,
        ST_POP_END,
        ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic               mode_reg, mode_next;
    logic [7:0]         ch_reg, ch_next;
    logic [3:0]         code_reg, code_next;
    logic [CNT_W-1:0]   stack_count_reg, stack_count_next;
    logic               in_number_reg, in_number_next;
    logic               prev_open_reg, prev_open_next;
    logic               error_seen_reg, error_seen_next;
    logic               hold_valid_reg, hold_valid_next;
    result_t            hold_reg, hold_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;
    logic               out_last_reg, out_last_next;

    logic [3:0]         stack_mem [STACK_DEPTH];
    logic               stack_we;
    logic [CNT_W-1:0]   top_cnt;
    logic [3:0]         top_code;
    logic               stack_full;
    logic               out_free;
    logic               can_emit;
    logic               emit_req;
    result_t            emit_data;
    logic               direct_req;
    result_t            direct_data;
    logic               is_digit;
    logic               is_closer;
    logic               op_pop;
    logic               close_pop;

    assign top_cnt    = stack_count_reg - CNT_W'(1);
    assign top_code   = stack_mem[top_cnt[IDX_W-1:0]];
    assign stack_full = (stack_count_reg == CNT_W'(STACK_DEPTH));
    assign out_free   = !out_valid_reg || m_tready;
    // a new word may enter the holding stage once its old word can move on
    assign can_emit   = !hold_valid_reg || out_free;

    assign is_digit  = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign is_closer = (ch_reg == CH_RPAREN) || (ch_reg == CH_RBRACK) ||
                       (ch_reg == CH_RBRACE);
    assign op_pop    = (stack_count_reg != '0) && (op_prio(top_code) != 2'd0) &&
                       (op_prio(code_reg) <= op_prio(top_code));
    assign close_pop = (stack_count_reg != '0) && (top_code != code_reg);

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        ch_next          = ch_reg;
        code_next        = code_reg;
        stack_count_next = stack_count_reg;
        in_number_next   = in_number_reg;
        prev_open_next   = prev_open_reg;
        error_seen_next  = error_seen_reg;
        hold_valid_next  = hold_valid_reg;
        hold_next        = hold_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_next         = out_reg;
        out_last_next    = out_last_reg;
        stack_we         = 1'b0;
        emit_req         = 1'b0;
        emit_data        = '{out_char: op_char(top_code), token_start: 1'b1,
                             end_of_expr: 1'b0, error_code: ERR_NONE};
        direct_req       = 1'b0;
        direct_data      = '{out_char: ch_reg, token_start: 1'b0,
                             end_of_expr: 1'b0, error_code: ERR_NONE};

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tuser[0];
                    ch_next    = s_tdata;
                    code_next  = op_code(s_tdata);
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                // holding stage is empty here, so a free output register covers all cases
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    if (mode_reg)
                    begin
                        if (error_seen_reg)
                        begin
                            direct_req             = 1'b1;
                            direct_data.out_char   = CH_NUL;
                            direct_data.end_of_expr = 1'b1;
                            stack_count_next       = '0;
                            in_number_next         = 1'b0;
                            prev_open_next         = 1'b1;
                            error_seen_next        = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_POP_END;
                        end
                    end
                    else if (!error_seen_reg)
                    begin
                        prev_open_next = (ch_reg == CH_LPAREN);
                        in_number_next = 1'b0;
                        if (ch_reg == CH_SPACE)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (is_digit)
                        begin
                            direct_req              = 1'b1;
                            direct_data.token_start = !in_number_reg;
                            in_number_next          = 1'b1;
                        end
                        else if (ch_reg == CH_DOT)
                        begin
                            direct_req = 1'b1;
                            if (in_number_reg)
                            begin
                                in_number_next = 1'b1;
                            end
                            else
                            begin
                                direct_data.error_code = ERR_INVALID;
                                error_seen_next        = 1'b1;
                            end
                        end
                        else if (is_closer)
                        begin
                            state_next = ST_POP_CLOSE;
                        end
                        else if ((code_reg >= OP_PLUS) && (code_reg <= OP_POW))
                        begin
                            if ((ch_reg == CH_MINUS) && prev_open_reg)
                            begin
                                emit_req           = 1'b1;
                                emit_data.out_char = CH_ZERO;
                            end
                            state_next = ST_POP_OP;
                        end
                        else if (code_reg >= OP_PAREN)
                        begin
                            if (stack_full)
                            begin
                                direct_req             = 1'b1;
                                direct_data.error_code = ERR_OVERFLOW;
                                error_seen_next        = 1'b1;
                            end
                            else
                            begin
                                stack_we         = 1'b1;
                                stack_count_next = stack_count_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            direct_req             = 1'b1;
                            direct_data.error_code = ERR_INVALID;
                            error_seen_next        = 1'b1;
                        end
                    end
                end
            end

            ST_POP_OP:
            begin
                if (op_pop)
                begin
                    if (can_emit)
                    begin
                        emit_req         = 1'b1;
                        stack_count_next = stack_count_reg - CNT_W'(1);
                    end
                end
                else if (stack_full)
                begin
                    if (can_emit)
                    begin
                        emit_req              = 1'b1;
                        emit_data.out_char    = ch_reg;
                        emit_data.token_start = 1'b0;
                        emit_data.error_code  = ERR_OVERFLOW;
                        error_seen_next       = 1'b1;
                        state_next            = ST_FIN;
                    end
                end
                else
                begin
                    stack_we         = 1'b1;
                    stack_count_next = stack_count_reg + CNT_W'(1);
                    state_next       = ST_FIN;
                end
            end

            ST_POP_CLOSE:
            begin
                if (close_pop)
                begin
                    if (can_emit)
                    begin
                        emit_req         = 1'b1;
                        stack_count_next = stack_count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    // drop the matching opener
                    if (stack_count_reg != '0)
                    begin
                        stack_count_next = stack_count_reg - CNT_W'(1);
                    end
                    state_next = ST_FIN;
                end
            end

            ST_POP_END:
            begin
                if (can_emit)
                begin
                    emit_req = 1'b1;
                    if (stack_count_reg != '0)
                    begin
                        stack_count_next = stack_count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        emit_data.out_char    = CH_NUL;
                        emit_data.token_start = 1'b0;
                        emit_data.end_of_expr = 1'b1;
                        in_number_next        = 1'b0;
                        prev_open_next        = 1'b1;
                        error_seen_next       = 1'b0;
                        state_next            = ST_FIN;
                    end
                end
            end

            ST_FIN:
            begin
                // the held word is the final one of this input word
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = hold_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit_req)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = hold_reg;
                out_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_next       = emit_data;
        end

        if (direct_req)
        begin
            out_valid_next = 1'b1;
            out_next       = direct_data;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= 1'b0;
            ch_reg          <= '0;
            code_reg        <= OP_NONE;
            stack_count_reg <= '0;
            in_number_reg   <= 1'b0;
            prev_open_reg   <= 1'b1;
            error_seen_reg  <= 1'b0;
            hold_valid_reg  <= 1'b0;
            hold_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            ch_reg          <= ch_next;
            code_reg        <= code_next;
            stack_count_reg <= stack_count_next;
            in_number_reg   <= in_number_next;
            prev_open_reg   <= prev_open_next;
            error_seen_reg  <= error_seen_next;
            hold_valid_reg  <= hold_valid_next;
            hold_reg        <= hold_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
            out_last_reg    <= out_last_next;
        end
    end

    // operator stack storage, written at the current count
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_count_reg[IDX_W-1:0]] <= code_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.out_char;
    assign m_tuser  = {out_reg.error_code, out_reg.end_of_expr, out_reg.token_start};
    assign m_tlast  = out_last_reg;

    `ITP_ASSERT_IMPL(a_idle_hold_empty, clk, rst_n, s_tready, !hold_valid_reg)
    `ITP_ASSERT_NEVER(a_stack_bound, clk, rst_n, stack_count_reg > CNT_W'(STACK_DEPTH))
    `ITP_ASSERT_IMPL(a_marker_last, clk, rst_n, m_tvalid && m_tuser[1], m_tlast)

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming infix-to-postfix converter. A short
// table of directed expressions, then random expressions: mostly well-formed
// ones with random content, plus noise and deeply nested runs that can overflow
// the operator stack. Every accepted character goes through a local
// shunting-yard predictor. Output words are checked field by field, in order,
// against what it predicts. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import itp_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int ITEM_TARGET    = 430;
    localparam int TAIL_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // how a directed row gets its expectation
    localparam logic [1:0] ROW_PREDICT = 2'd0;
    localparam logic [1:0] ROW_NONE    = 2'd1;
    localparam logic [1:0] ROW_ONE     = 2'd2;

    localparam int STYLE_TIDY  = 0;
    localparam int STYLE_NOISE = 1;
    localparam int STYLE_DEEP  = 2;

    localparam logic [2:0][7:0] OPENER_SET   = {CH_LBRACE, CH_LBRACK, CH_LPAREN};
    localparam logic [2:0][7:0] CLOSER_SET   = {CH_RBRACE, CH_RBRACK, CH_RPAREN};
    localparam logic [5:0][7:0] OPERATOR_SET = {CH_POW, CH_MOD, CH_DIV,
                                                CH_MUL, CH_MINUS, CH_PLUS};

    typedef struct packed {
        logic [7:0] out_char;
        logic       token_start;
        logic       end_of_expr;
        logic [1:0] error_code;
        logic       last;
    } postfix_word_t;

    typedef struct packed {
        logic          mode;
        logic [7:0]    ch;
        logic [1:0]    kind;
        postfix_word_t word;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [0:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;

    // predictor state
    logic [3:0] op_mem [STACK_DEPTH];
    int         pr_depth  = 0;
    logic       pr_in_num = 1'b0;
    logic       pr_open   = 1'b1;
    logic       pr_err    = 1'b0;

    postfix_word_t produced[$];
    postfix_word_t postfix_due[$];
    logic [8:0]    expr_q[$];
    stim_row_t     directed_rows[$];

    int   bad_words    = 0;
    int   live_items   = 0;
    int   stall_cycles = 0;
    logic tx_burst     = 1'b0;
    logic rx_burst     = 1'b0;

    infix_to_postfix_converter_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // shunting-yard predictor
    // ------------------------------------------------------------------------
    function automatic logic [3:0] code_for_char(input logic [7:0] c);
        case (c)
            CH_PLUS:   return OP_PLUS;
            CH_MINUS:  return OP_MINUS;
            CH_MUL:    return OP_MUL;
            CH_DIV:    return OP_DIV;
            CH_MOD:    return OP_MOD;
            CH_POW:    return OP_POW;
            CH_LPAREN: return OP_PAREN;
            CH_LBRACK: return OP_BRACK;
            CH_LBRACE: return OP_BRACE;
            default:   return OP_NONE;
        endcase
    endfunction

    function automatic logic [7:0] char_for_code(input logic [3:0] code);
        case (code)
            OP_PLUS:  return CH_PLUS;
            OP_MINUS: return CH_MINUS;
            OP_MUL:   return CH_MUL;
            OP_DIV:   return CH_DIV;
            OP_MOD:   return CH_MOD;
            OP_POW:   return CH_POW;
            OP_PAREN: return CH_LPAREN;
            OP_BRACK: return CH_LBRACK;
            OP_BRACE: return CH_LBRACE;
            default:  return CH_NUL;
        endcase
    endfunction

    // openers rank 0, so they stop the popping
    function automatic int rank_for_code(input logic [3:0] code);
        case (code)
            OP_PLUS, OP_MINUS: return 1;
            OP_MUL, OP_DIV:    return 2;
            OP_MOD, OP_POW:    return 3;
            default:           return 0;
        endcase
    endfunction

    function automatic void emit_word(input logic [7:0] c, input logic start,
                                      input logic eoe, input logic [1:0] err);
        postfix_word_t w;
        w.out_char    = c;
        w.token_start = start;
        w.end_of_expr = eoe;
        w.error_code  = err;
        w.last        = 1'b0;
        produced.insert(produced.size(), w);
    endfunction

    function automatic void push_or_overflow(input logic [3:0] code, input logic [7:0] c);
        if (pr_depth >= STACK_DEPTH)
        begin
            emit_word(c, 1'b0, 1'b0, ERR_OVERFLOW);
            pr_err = 1'b1;
        end
        else
        begin
            op_mem[pr_depth] = code;
            pr_depth++;
        end
    endfunction

    function automatic void shunt_char(input logic mode, input logic [7:0] c);
        logic       was_open;
        logic       was_num;
        logic [3:0] code;
        logic [3:0] match;
        produced.delete();
        if (mode == MODE_END)
        begin
            if (!pr_err)
            begin
                while (pr_depth > 0)
                begin
                    emit_word(char_for_code(op_mem[pr_depth - 1]), 1'b1, 1'b0, ERR_NONE);
                    pr_depth--;
                end
            end
            emit_word(CH_NUL, 1'b0, 1'b1, ERR_NONE);
            pr_depth  = 0;
            pr_in_num = 1'b0;
            pr_open   = 1'b1;
            pr_err    = 1'b0;
        end
        else if (!pr_err)
        begin
            was_open  = pr_open;
            was_num   = pr_in_num;
            code      = code_for_char(c);
            pr_open   = (c == CH_LPAREN);
            pr_in_num = 1'b0;
            if (c == CH_SPACE)
            begin
                // skipped, but it still breaks a number
            end
            else if (c >= CH_ZERO && c <= CH_NINE)
            begin
                emit_word(c, !was_num, 1'b0, ERR_NONE);
                pr_in_num = 1'b1;
            end
            else if (c == CH_DOT)
            begin
                if (was_num)
                begin
                    emit_word(c, 1'b0, 1'b0, ERR_NONE);
                    pr_in_num = 1'b1;
                end
                else
                begin
                    emit_word(c, 1'b0, 1'b0, ERR_INVALID);
                    pr_err = 1'b1;
                end
            end
            else if (code >= OP_PLUS && code <= OP_POW)
            begin
                if (c == CH_MINUS && was_open)
                    emit_word(CH_ZERO, 1'b1, 1'b0, ERR_NONE);
                while (pr_depth > 0 && rank_for_code(op_mem[pr_depth - 1]) != 0 &&
                       rank_for_code(code) <= rank_for_code(op_mem[pr_depth - 1]))
                begin
                    emit_word(char_for_code(op_mem[pr_depth - 1]), 1'b1, 1'b0, ERR_NONE);
                    pr_depth--;
                end
                push_or_overflow(code, c);
            end
            else if (code >= OP_PAREN)
            begin
                push_or_overflow(code, c);
            end
            else if (c == CH_RPAREN || c == CH_RBRACK || c == CH_RBRACE)
            begin
                match = (c == CH_RPAREN) ? OP_PAREN : (c == CH_RBRACK) ? OP_BRACK : OP_BRACE;
                // other openers on the way are emitted like operators
                while (pr_depth > 0 && op_mem[pr_depth - 1] != match)
                begin
                    emit_word(char_for_code(op_mem[pr_depth - 1]), 1'b1, 1'b0, ERR_NONE);
                    pr_depth--;
                end
                if (pr_depth > 0)
                    pr_depth--;
            end
            else
            begin
                emit_word(c, 1'b0, 1'b0, ERR_INVALID);
                pr_err = 1'b1;
            end
        end
        if (produced.size() > 0)
            produced[produced.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap(input logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic stim_row_t make_row(input logic [1:0] kind, input logic mode,
                                           input logic [7:0] c, input logic [7:0] oc,
                                           input logic start, input logic eoe,
                                           input logic [1:0] err);
        stim_row_t r;
        r.mode             = mode;
        r.ch               = c;
        r.kind             = kind;
        r.word.out_char    = oc;
        r.word.token_start = start;
        r.word.end_of_expr = eoe;
        r.word.error_code  = err;
        r.word.last        = 1'b1;
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] kind, input logic mode,
                                    input logic [7:0] c, input logic [7:0] oc,
                                    input logic start, input logic eoe,
                                    input logic [1:0] err);
        directed_rows.insert(directed_rows.size(),
                             make_row(kind, mode, c, oc, start, eoe, err));
    endfunction

    function automatic void add_char(input logic mode, input logic [7:0] c);
        expr_q.insert(expr_q.size(), {mode, c});
    endfunction

    function automatic void add_number();
        int n;
        int k;
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++)
            add_char(MODE_CHAR, 8'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0)
        begin
            add_char(MODE_CHAR, CH_DOT);
            n = $urandom_range(0, 2);
            for (k = 0; k < n; k++)
                add_char(MODE_CHAR, 8'(CH_ZERO + $urandom_range(0, 9)));
        end
    endfunction

    function automatic void build_expression(input int style, input int deep_n,
                                             input logic paren_last);
        logic [1:0] opens[$];
        logic [1:0] b;
        logic       need_operand;
        int         ntok;
        int         k;
        expr_q.delete();
        if (style == STYLE_DEEP)
        begin
            for (k = 0; k < deep_n; k++)
                add_char(MODE_CHAR, OPENER_SET[$urandom_range(0, 2)]);
            if (paren_last)
                expr_q[deep_n - 1] = {MODE_CHAR, CH_LPAREN};
            // leading minus: after a '(' on a full stack, zero first, then the overflow
            add_char(MODE_CHAR, CH_MINUS);
            add_number();
            ntok = $urandom_range(0, 4);
            for (k = 0; k < ntok; k++)
                add_char(MODE_CHAR, CLOSER_SET[$urandom_range(0, 2)]);
        end
        else if (style == STYLE_NOISE)
        begin
            ntok = $urandom_range(1, 8);
            for (k = 0; k < ntok; k++)
                add_char(MODE_CHAR, 8'($urandom_range(0, 255)));
        end
        else
        begin
            need_operand = 1'b1;
            if ($urandom_range(0, 3) == 0)
                add_char(MODE_CHAR, CH_MINUS);
            ntok = $urandom_range(1, 14);
            for (k = 0; k < ntok; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_char(MODE_CHAR, CH_SPACE);
                if (need_operand)
                begin
                    if ($urandom_range(0, 3) == 0 && opens.size() < 6)
                    begin
                        b = 2'($urandom_range(0, 2));
                        opens.insert(opens.size(), b);
                        add_char(MODE_CHAR, OPENER_SET[b]);
                        if (b == 0 && $urandom_range(0, 2) == 0)
                            add_char(MODE_CHAR, CH_MINUS);
                    end
                    else
                    begin
                        add_number();
                        need_operand = 1'b0;
                    end
                end
                else if (opens.size() > 0 && $urandom_range(0, 2) == 0)
                begin
                    b = opens.pop_back();
                    if ($urandom_range(0, 19) == 0)
                        b = 2'($urandom_range(0, 2));    // mismatched closer now and then
                    add_char(MODE_CHAR, CLOSER_SET[b]);
                end
                else
                begin
                    add_char(MODE_CHAR, OPERATOR_SET[$urandom_range(0, 5)]);
                    need_operand = 1'b1;
                end
            end
            if (need_operand)
                add_number();
            while (opens.size() > 0 && $urandom_range(0, 7) != 0)
                add_char(MODE_CHAR, CLOSER_SET[opens.pop_back()]);
            if ($urandom_range(0, 9) == 0)
                expr_q.insert($urandom_range(0, expr_q.size()),
                              {MODE_CHAR, 8'($urandom_range(0, 255))});
        end
        add_char(MODE_END, 8'($urandom_range(0, 255)));
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input logic mode, input logic [7:0] c, input logic [1:0] kind,
                             input postfix_word_t typed_w);
        int gap;
        gap = pick_gap(tx_burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        live_items++;
        shunt_char(mode, c);
        if (kind == ROW_NONE)
        begin
            produced.delete();
        end
        else if (kind == ROW_ONE)
        begin
            produced.delete();
            produced.insert(0, typed_w);
        end
        foreach (produced[i])
            postfix_due.insert(postfix_due.size(), produced[i]);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        if (postfix_due.size() != 0)
        begin
            s_tvalid <= 1'b0;
            while (postfix_due.size() != 0)
                @(negedge clk);
        end
    endtask

    task automatic report_mismatch(input string what);
        bad_words++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // output side: stalls and checking
    // ------------------------------------------------------------------------
    initial
    begin : rx_stall
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                rx_burst = !rx_burst;
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                hold = pick_gap(rx_burst);
            end
        end
    end

    always @(posedge clk)
    begin : check_word
        postfix_word_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (postfix_due.size() == 0)
            begin
                report_mismatch($sformatf("word %h user %h with nothing expected",
                                          m_tdata, m_tuser));
            end
            else
            begin
                w = postfix_due.pop_front();
                if (m_tdata !== w.out_char)
                    report_mismatch($sformatf("out_char %h, want %h", m_tdata, w.out_char));
                if (m_tuser[0] !== w.token_start)
                    report_mismatch($sformatf("token_start %b, want %b", m_tuser[0],
                                              w.token_start));
                if (m_tuser[1] !== w.end_of_expr)
                    report_mismatch($sformatf("end_of_expr %b, want %b", m_tuser[1],
                                              w.end_of_expr));
                if (m_tuser[3:2] !== w.error_code)
                    report_mismatch($sformatf("error_code %0d, want %0d", m_tuser[3:2],
                                              w.error_code));
                if (m_tlast !== w.last)
                    report_mismatch($sformatf("last %b, want %b", m_tlast, w.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int   style;
        int   r;
        logic first;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = MODE_CHAR;

        // "7.9+[(-3^2)}" : number with dot, leading minus after '(',
        // closer with no matching opener
        add_row(ROW_ONE, MODE_CHAR, "7", "7", 1'b1, 1'b0, ERR_NONE);
        add_row(ROW_ONE, MODE_CHAR, ".", ".", 1'b0, 1'b0, ERR_NONE);
        add_row(ROW_ONE, MODE_CHAR, "9", "9", 1'b0, 1'b0, ERR_NONE);
        add_row(ROW_NONE, MODE_CHAR, CH_PLUS, 0, 0, 0, ERR_NONE);
        add_row(ROW_NONE, MODE_CHAR, CH_LBRACK, 0, 0, 0, ERR_NONE);
        add_row(ROW_NONE, MODE_CHAR, CH_LPAREN, 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, CH_MINUS, 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, "3", 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, CH_POW, 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, "2", 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, CH_RPAREN, 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, CH_RBRACE, 0, 0, 0, ERR_NONE);
        add_row(ROW_ONE, MODE_END, 8'h00, CH_NUL, 1'b0, 1'b1, ERR_NONE);
        // "-4*{8/1%2}" : leading minus at start, flush at the end
        add_row(ROW_PREDICT, MODE_CHAR, CH_MINUS, 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, "4", 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, CH_MUL, 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, CH_LBRACE, 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, "8", 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, CH_DIV, 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, "1", 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, CH_MOD, 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, "2", 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_CHAR, CH_RBRACE, 0, 0, 0, ERR_NONE);
        add_row(ROW_PREDICT, MODE_END, 8'h5A, 0, 0, 0, ERR_NONE);
        // space, stray dot, ignored rest, then top-bit byte
        add_row(ROW_NONE, MODE_CHAR, CH_SPACE, 0, 0, 0, ERR_NONE);
        add_row(ROW_ONE, MODE_CHAR, CH_DOT, CH_DOT, 1'b0, 1'b0, ERR_INVALID);
        add_row(ROW_NONE, MODE_CHAR, "a", 0, 0, 0, ERR_NONE);
        add_row(ROW_ONE, MODE_END, 8'h00, CH_NUL, 1'b0, 1'b1, ERR_NONE);
        add_row(ROW_ONE, MODE_CHAR, 8'hFF, 8'hFF, 1'b0, 1'b0, ERR_INVALID);
        add_row(ROW_ONE, MODE_END, 8'hFF, CH_NUL, 1'b0, 1'b1, ERR_NONE);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].mode, directed_rows[i].ch, directed_rows[i].kind,
                      directed_rows[i].word);
        wait_for_drain();

        first = 1'b1;
        while (live_items < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            style = (r < 76) ? STYLE_TIDY : (r < 90) ? STYLE_NOISE : STYLE_DEEP;
            if (first)
                build_expression(STYLE_DEEP, STACK_DEPTH, 1'b1);
            else
                build_expression(style, $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 3),
                                 1'($urandom_range(0, 1)));
            first = 1'b0;
            if ($urandom_range(0, 5) == 0)
                tx_burst = !tx_burst;
            foreach (expr_q[i])
                send_word(expr_q[i][8], expr_q[i][7:0], ROW_PREDICT, '0);
            if ($urandom_range(0, 7) == 0)
                wait_for_drain();
        end

        s_tvalid <= 1'b0;
        while (postfix_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (bad_words == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
